// ===== rtl/core/fixed_partition_fit_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Fixed partition fit allocator assertion macros
// Shared concurrent assertion forms, clocked on i_clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_CORE_ASSERT_SVH

`define FPFA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("fpfa: same-cycle check failed");

`define FPFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("fpfa: next-cycle check failed");

`endif

// ===== rtl/core/fpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed partition fit allocator package
// Command codes, status codes, sequencer states and fit unit control.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    // The block index ports are three bits wide, so the table size is fixed.
    localparam int NUM_BLOCKS = 8;

    typedef enum logic [2:0] {
        CMD_SET   = 3'd0,
        CMD_FIRST = 3'd1,
        CMD_NEXT  = 3'd2,
        CMD_BEST  = 3'd3,
        CMD_WORST = 3'd4
    } t_cmd;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_SCAN,
        S_FIN,
        S_RES
    } t_state;

    typedef struct packed {
        logic clear;
        logic cmp;
        t_cmd policy;
    } t_fit_ctl;

endpackage

// ===== rtl/core/fpfa_ram.sv =====
// ----------------------------------------------------------------------------
// Fixed partition fit allocator RAM
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module fpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fpfa_fit_unit.sv =====
// ----------------------------------------------------------------------------
// Fixed partition fit allocator fit unit
// Shared compare and leftover unit that keeps the best candidate of a scan.
// ----------------------------------------------------------------------------
module fpfa_fit_unit import fpfa_pkg::*; #(
    parameter int SIZE_BITS  = 16
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  t_fit_ctl                                       i_ctl,
    input  logic [SIZE_BITS-1:0]                           i_size,
    input  logic [15:0]                                    i_req,
    input  logic [(NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1)-1:0] i_idx,
    input  logic                                           i_taken,
    output logic                                           o_found,
    output logic [(NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1)-1:0] o_pick
);

    localparam int IDX_W = NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1;
    localparam int W     = SIZE_BITS > 16 ? SIZE_BITS : 16;

    logic             r_found;
    logic [W-1:0]     r_best;
    logic [IDX_W-1:0] r_pick;
    logic [W-1:0]     size_x;
    logic [W-1:0]     req_x;
    logic [W-1:0]     left;
    logic             fits;
    logic             better;
    logic             take;

    assign size_x = W'(i_size);
    assign req_x  = W'(i_req);
    assign fits   = !i_taken && (size_x >= req_x);
    assign left   = size_x - req_x;

    always_comb begin
        case (i_ctl.policy)
            CMD_BEST:  better = left < r_best;
            CMD_WORST: better = left > r_best;
            default:   better = 1'b0;
        endcase
    end

    assign take = i_ctl.cmp && fits && (!r_found || better);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best <= left;
            r_pick <= i_idx;
        end
    end

    assign o_found = r_found;
    assign o_pick  = r_pick;

endmodule

// ===== rtl/core/fixed_partition_fit_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Fixed partition fit allocator core
// Partition table with first, next, best and worst fit allocation.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and its one result
// appears on o_status and o_block_index for a single cycle with
// o_result_valid; the receiver cannot stall it. A set item, or an unknown
// command, keeps busy high through the dispatch and result states. An
// allocation adds the scan and finish states; the scan reads n partition
// sizes, one per cycle, from the size RAM into one shared fit comparator,
// where n is blocks_in_use clamped to 1..NUM_BLOCKS. The result strobe
// comes as busy falls, and a new item may be started in that same cycle.
module fixed_partition_fit_allocator_core import fpfa_pkg::*; #(
    parameter int SIZE_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_request_size,
    input  logic [2:0]  i_target_block,
    output logic        o_result_valid,
    output logic [1:0]  o_status,
    output logic [2:0]  o_block_index
);

    localparam int IDX_W = NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int CW    = CNT_W > 4 ? CNT_W : 4;

    t_state               r_state;
    t_state               n_state;
    logic [3:0]           r_biu;
    logic [2:0]           r_cmd;
    logic [15:0]          r_req;
    logic [2:0]           r_target;
    logic [NUM_BLOCKS-1:0] r_taken;
    logic [NUM_BLOCKS-1:0] n_taken;
    logic [NUM_BLOCKS-1:0] r_valid;
    logic [NUM_BLOCKS-1:0] n_valid;
    logic [IDX_W-1:0]     r_nfs;
    logic [IDX_W-1:0]     n_nfs;
    logic [IDX_W-1:0]     r_addr;
    logic [IDX_W-1:0]     n_addr;
    logic [CNT_W-1:0]     r_step;
    logic [CNT_W-1:0]     n_step;
    logic                 r_cmp;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_ent_vld;
    logic                 r_out_vld;
    logic                 n_out_vld;
    logic [1:0]           r_status;
    logic [1:0]           n_status;
    logic [2:0]           r_index;
    logic [2:0]           n_index;

    logic [CW-1:0]        eff_n;
    logic [IDX_W-1:0]     last_addr;
    logic [IDX_W-1:0]     start_idx;
    logic                 tgt_ok;
    logic                 scan_end;
    logic [IDX_W-1:0]     tgt_idx;
    logic                 ram_we;
    logic [SIZE_BITS-1:0] ram_rdata;
    logic [SIZE_BITS-1:0] ent_size;
    t_fit_ctl             fit_ctl;
    logic                 fit_found;
    logic [IDX_W-1:0]     fit_pick;

    always_comb begin
        if (r_biu == 4'd0) begin
            eff_n = CW'(1);
        end else if (CW'(r_biu) > CW'(NUM_BLOCKS)) begin
            eff_n = CW'(NUM_BLOCKS);
        end else begin
            eff_n = CW'(r_biu);
        end
    end

    assign last_addr = IDX_W'(eff_n - CW'(1));
    assign start_idx = (CW'(r_nfs) < eff_n) ? r_nfs : '0;
    assign tgt_ok    = CW'(r_target) < eff_n;
    assign tgt_idx   = IDX_W'(r_target);
    assign scan_end  = CW'(r_step) == (eff_n - CW'(1));
    assign busy      = r_state != S_IDLE;

    always_comb begin
        case (r_state)
            S_IDLE: begin
                n_state = start ? S_DISP : S_IDLE;
            end
            S_DISP: begin
                if (r_cmd inside {CMD_FIRST, CMD_NEXT, CMD_BEST, CMD_WORST}) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_RES;
                end
            end
            S_SCAN: begin
                n_state = scan_end ? S_FIN : S_SCAN;
            end
            S_FIN: begin
                n_state = S_RES;
            end
            S_RES: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_addr         = r_addr;
        n_step         = r_step;
        n_taken        = r_taken;
        n_valid        = r_valid;
        n_nfs          = r_nfs;
        n_out_vld      = 1'b0;
        n_status       = r_status;
        n_index        = r_index;
        ram_we         = 1'b0;
        fit_ctl.clear  = 1'b0;
        fit_ctl.cmp    = r_cmp;
        fit_ctl.policy = t_cmd'(r_cmd);
        case (r_state)
            S_DISP: begin
                fit_ctl.clear = 1'b1;
                n_step        = '0;
                n_addr        = (r_cmd == CMD_NEXT) ? start_idx : '0;
            end
            S_SCAN: begin
                n_step = r_step + CNT_W'(1);
                n_addr = (r_addr == last_addr) ? '0 : r_addr + IDX_W'(1);
            end
            S_RES: begin
                n_out_vld = 1'b1;
                case (r_cmd)
                    CMD_SET: begin
                        if (tgt_ok) begin
                            ram_we           = 1'b1;
                            n_valid[tgt_idx] = 1'b1;
                            n_taken[tgt_idx] = 1'b0;
                            n_status         = ST_OK;
                            n_index          = r_target;
                        end else begin
                            n_status = ST_RANGE;
                            n_index  = 3'd0;
                        end
                    end
                    CMD_FIRST, CMD_NEXT, CMD_BEST, CMD_WORST: begin
                        if (fit_found) begin
                            n_taken[fit_pick] = 1'b1;
                            n_status          = ST_OK;
                            n_index           = 3'(fit_pick);
                            if (r_cmd == CMD_NEXT) begin
                                n_nfs = fit_pick;
                            end
                        end else begin
                            n_status = ST_NOFIT;
                            n_index  = 3'd0;
                        end
                    end
                    default: begin
                        n_status = ST_NOFIT;
                        n_index  = 3'd0;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_biu     <= 4'd8;
            r_taken   <= '0;
            r_valid   <= '0;
            r_nfs     <= '0;
            r_cmp     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_taken   <= n_taken;
            r_valid   <= n_valid;
            r_nfs     <= n_nfs;
            r_cmp     <= r_state == S_SCAN;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_biu <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd    <= i_command;
            r_req    <= i_request_size;
            r_target <= i_target_block;
        end
        r_addr    <= n_addr;
        r_step    <= n_step;
        r_cmp_idx <= r_addr;
        r_ent_vld <= r_valid[r_addr];
        r_status  <= n_status;
        r_index   <= n_index;
    end

    fpfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tgt_idx),
        .i_wdata (SIZE_BITS'(r_req)),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign ent_size = r_ent_vld ? ram_rdata : '0;

    fpfa_fit_unit #(
        .SIZE_BITS  (SIZE_BITS)
    ) u_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fit_ctl),
        .i_size  (ent_size),
        .i_req   (r_req),
        .i_idx   (r_cmp_idx),
        .i_taken (r_taken[r_cmp_idx]),
        .o_found (fit_found),
        .o_pick  (fit_pick)
    );

    assign o_result_valid = r_out_vld;
    assign o_status       = r_status;
    assign o_block_index  = r_index;

`include "fixed_partition_fit_allocator_core_assert.svh"

    `FPFA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `FPFA_ASSERT_SAME(a_result_idle, o_result_valid, !busy)
    `FPFA_ASSERT_SAME(a_fail_index, o_result_valid && (o_status != ST_OK), o_block_index == 3'd0)
    `FPFA_ASSERT_SAME(a_scan_bound, r_state == S_SCAN, CW'(r_step) < eff_n)

endmodule
